// ===== hdl/pc2rs_pkg.sv =====
// Package with shared types, constants and tables for the range scan binning block.
`timescale 1ns / 1ps
`default_nettype none
package pc2rs_pkg;

	localparam int NUM_BINS_DEF = 719;
	localparam int CORDIC_STEPS = 17;
	localparam int SQRT_STEPS = 24;
	localparam int PI_Q16 = 205887;
	localparam logic [23:0] EMPTY_RANGE = 24'hFFFFFF;

	localparam logic [2:0] CFG_RANGE_MIN = 3'd0;
	localparam logic [2:0] CFG_RANGE_MAX = 3'd1;
	localparam logic [2:0] CFG_ANGLE_MIN = 3'd2;
	localparam logic [2:0] CFG_ANGLE_MAX = 3'd3;
	localparam logic [2:0] CFG_BINS_PER_RAD = 3'd4;
	localparam logic [2:0] CFG_EMPTY_AS_MAX = 3'd5;

	localparam logic [2:0] RES_STORED = 3'd0;
	localparam logic [2:0] RES_NOT_SMALLER = 3'd1;
	localparam logic [2:0] RES_INVALID = 3'd2;
	localparam logic [2:0] RES_BELOW_MIN = 3'd3;
	localparam logic [2:0] RES_ABOVE_MAX = 3'd4;
	localparam logic [2:0] RES_ANGLE_OUT = 3'd5;
	localparam logic [2:0] RES_BIN_READ = 3'd6;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_SQY, S_ITER, S_CHECK, S_BMUL,
		S_BRD, S_BCMP, S_RWAIT, S_DONE
	} state_t;

	typedef struct packed {
		logic clear_wr;
		logic load;
		logic decode;
		logic sq_y;
		logic iter;
		logic check;
		logic bmul;
		logic brd;
		logic bcmp;
		logic rwait;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic is_read;
		logic pt_valid;
		logic iter_done;
		logic rejected;
		logic out_busy;
	} stat_t;

	function automatic logic [15:0] atan_q16(input logic [4:0] i);
		logic [15:0] v;
		case (i)
			5'd0: v = 16'd51472;
			5'd1: v = 16'd30386;
			5'd2: v = 16'd16055;
			5'd3: v = 16'd8150;
			5'd4: v = 16'd4091;
			5'd5: v = 16'd2047;
			5'd6: v = 16'd1024;
			5'd7: v = 16'd512;
			5'd8: v = 16'd256;
			5'd9: v = 16'd128;
			5'd10: v = 16'd64;
			5'd11: v = 16'd32;
			5'd12: v = 16'd16;
			5'd13: v = 16'd8;
			5'd14: v = 16'd4;
			5'd15: v = 16'd2;
			5'd16: v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/pc2rs_ctrl.sv =====
// Controller state machine that sequences the clearing pass and each item.
`timescale 1ns / 1ps
`default_nettype none
module pc2rs_ctrl
	import pc2rs_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clear_done) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_n = S_DECODE;
			end
			S_DECODE: begin
				if (stat.is_read) state_n = S_RWAIT;
				else if (!stat.pt_valid) state_n = S_DONE;
				else state_n = S_SQY;
			end
			S_SQY: state_n = S_ITER;
			S_ITER: begin
				if (stat.iter_done) state_n = S_CHECK;
			end
			S_CHECK: state_n = S_BMUL;
			S_BMUL: begin
				if (stat.rejected) state_n = S_DONE;
				else state_n = S_BRD;
			end
			S_BRD: state_n = S_BCMP;
			S_BCMP: state_n = S_DONE;
			S_RWAIT: state_n = S_DONE;
			S_DONE: begin
				if (!stat.out_busy) state_n = S_IDLE;
			end
			default: state_n = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			S_CLEAR: cmd.clear_wr = 1'b1;
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_DECODE: cmd.decode = 1'b1;
			S_SQY: cmd.sq_y = 1'b1;
			S_ITER: cmd.iter = 1'b1;
			S_CHECK: cmd.check = 1'b1;
			S_BMUL: cmd.bmul = 1'b1;
			S_BRD: cmd.brd = 1'b1;
			S_BCMP: cmd.bcmp = 1'b1;
			S_RWAIT: cmd.rwait = 1'b1;
			S_DONE: cmd.out_load = !stat.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/pc2rs_dp.sv =====
// Datapath with configuration registers, square root, CORDIC, binning and bin memory.
`timescale 1ns / 1ps
`default_nettype none
module pc2rs_dp
	import pc2rs_pkg::*;
#(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output stat_t                   stat,
	input  wire logic               cfg_valid,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [23:0]        cfg_data,
	input  wire logic               action,
	input  wire logic signed [23:0] x_coord,
	input  wire logic signed [23:0] y_coord,
	input  wire logic               point_valid,
	input  wire logic [9:0]         bin_select,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic [9:0]              bin_index,
	output logic [23:0]             range_value
);

	localparam int BIN_W = $clog2(NUM_BINS);

	logic [23:0] range_min_q;
	logic [23:0] range_max_q;
	logic signed [18:0] angle_min_q;
	logic signed [18:0] angle_max_q;
	logic [23:0] bpr_q;
	logic empty_max_q;

	logic action_q;
	logic signed [23:0] x_q;
	logic signed [23:0] y_q;
	logic valid_q;
	logic [9:0] sel_q;

	logic [47:0] sq_q;
	logic [47:0] sum_q;
	logic [25:0] rem_q;
	logic [23:0] root_q;
	logic [4:0] cnt_q;
	logic signed [34:0] cx_q;
	logic signed [34:0] cy_q;
	logic signed [20:0] z_q;
	logic zero_q;
	logic rej_q;
	logic [19:0] off_q;
	logic [43:0] prod_q;
	logic [BIN_W-1:0] bin_q;
	logic [BIN_W-1:0] clr_q;

	logic [2:0] res_st_q;
	logic [9:0] res_idx_q;
	logic [23:0] res_val_q;
	logic out_valid_q;
	logic [2:0] out_st_q;
	logic [9:0] out_idx_q;
	logic [23:0] out_val_q;

	logic [23:0] mem [NUM_BINS];
	logic [23:0] rd_q;

	logic sel_ok;
	logic [25:0] rem_n;
	logic [25:0] trial;
	logic signed [34:0] xsh;
	logic signed [34:0] ysh;
	logic signed [34:0] x_init;
	logic signed [34:0] y_init;
	logic signed [20:0] z_eff;
	logic signed [20:0] ang_min_x;
	logic signed [20:0] ang_max_x;
	logic signed [20:0] off_full;
	logic [11:0] braw;
	logic [BIN_W-1:0] bclamp;
	logic [BIN_W-1:0] mem_addr;
	logic mem_we;
	logic [23:0] mem_wd;
	logic [23:0] rd_eff;

	assign sel_ok = 32'(sel_q) < NUM_BINS;
	assign rem_n = {rem_q[23:0], sum_q[47:46]};
	assign trial = {root_q, 2'b01};
	assign xsh = cx_q >>> cnt_q;
	assign ysh = cy_q >>> cnt_q;
	assign x_init = 35'(x_q) <<< 8;
	assign y_init = 35'(y_q) <<< 8;
	assign z_eff = zero_q ? 21'sd0 : z_q;
	assign ang_min_x = 21'(angle_min_q);
	assign ang_max_x = 21'(angle_max_q);
	assign off_full = z_eff - ang_min_x;
	assign braw = prod_q[43:32];
	assign bclamp = (32'(braw) > NUM_BINS - 1) ? BIN_W'(NUM_BINS - 1) : BIN_W'(braw);

	always_comb begin
		mem_addr = clr_q;
		mem_we = 1'b0;
		mem_wd = EMPTY_RANGE;
		if (cmd.clear_wr) begin
			mem_we = 1'b1;
		end else if (cmd.decode) begin
			mem_addr = BIN_W'(sel_q);
		end else if (cmd.brd) begin
			mem_addr = bclamp;
		end else if (cmd.bcmp) begin
			mem_addr = bin_q;
			mem_we = root_q < rd_q;
			mem_wd = root_q;
		end else if (cmd.rwait) begin
			mem_addr = BIN_W'(sel_q);
			mem_we = sel_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wd;
		rd_q <= mem[mem_addr];
	end

	always_comb begin
		rd_eff = sel_ok ? rd_q : EMPTY_RANGE;
		if (rd_eff == EMPTY_RANGE && empty_max_q) rd_eff = range_max_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= 24'd7864;
			range_max_q <= 24'd229376;
			angle_min_q <= -19'sd205887;
			angle_max_q <= 19'sd205887;
			bpr_q <= 24'd7489471;
			empty_max_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RANGE_MIN: range_min_q <= cfg_data;
				CFG_RANGE_MAX: range_max_q <= cfg_data;
				CFG_ANGLE_MIN: angle_min_q <= cfg_data[18:0];
				CFG_ANGLE_MAX: angle_max_q <= cfg_data[18:0];
				CFG_BINS_PER_RAD: bpr_q <= cfg_data;
				CFG_EMPTY_AS_MAX: empty_max_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_wr) clr_q <= clr_q + 1'b1;
			if (cmd.sq_y) cnt_q <= '0;
			else if (cmd.iter) cnt_q <= cnt_q + 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			x_q <= x_coord;
			y_q <= y_coord;
			valid_q <= point_valid;
			sel_q <= bin_select;
		end
		if (cmd.decode) begin
			sq_q <= 48'(x_q * x_q);
			zero_q <= (x_q == 24'sd0) && (y_q == 24'sd0);
			if (x_q < 0) begin
				cx_q <= -x_init;
				cy_q <= -y_init;
				z_q <= (y_q >= 0) ? 21'sd205887 : -21'sd205887;
			end else begin
				cx_q <= x_init;
				cy_q <= y_init;
				z_q <= '0;
			end
			res_st_q <= RES_INVALID;
			res_idx_q <= '0;
			res_val_q <= '0;
		end
		if (cmd.sq_y) begin
			sum_q <= sq_q + 48'(y_q * y_q);
			rem_q <= '0;
			root_q <= '0;
		end
		if (cmd.iter) begin
			sum_q <= {sum_q[45:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q <= rem_n - trial;
				root_q <= {root_q[22:0], 1'b1};
			end else begin
				rem_q <= rem_n;
				root_q <= {root_q[22:0], 1'b0};
			end
			if (cnt_q < 5'(CORDIC_STEPS)) begin
				if (cy_q > 0) begin
					cx_q <= cx_q + ysh;
					cy_q <= cy_q - xsh;
					z_q <= z_q + 21'(atan_q16(cnt_q));
				end else begin
					cx_q <= cx_q - ysh;
					cy_q <= cy_q + xsh;
					z_q <= z_q - 21'(atan_q16(cnt_q));
				end
			end
		end
		if (cmd.check) begin
			off_q <= 20'(off_full);
			res_val_q <= root_q;
			res_idx_q <= '0;
			rej_q <= 1'b1;
			if (root_q < range_min_q) res_st_q <= RES_BELOW_MIN;
			else if (root_q > range_max_q) res_st_q <= RES_ABOVE_MAX;
			else if (z_eff < ang_min_x || z_eff > ang_max_x) res_st_q <= RES_ANGLE_OUT;
			else rej_q <= 1'b0;
		end
		if (cmd.bmul) prod_q <= off_q * bpr_q;
		if (cmd.brd) bin_q <= bclamp;
		if (cmd.bcmp) begin
			res_idx_q <= 10'(bin_q);
			res_st_q <= (root_q < rd_q) ? RES_STORED : RES_NOT_SMALLER;
		end
		if (cmd.rwait) begin
			res_st_q <= RES_BIN_READ;
			res_idx_q <= sel_q;
			res_val_q <= rd_eff;
		end
		if (cmd.out_load) begin
			out_st_q <= res_st_q;
			out_idx_q <= res_idx_q;
			out_val_q <= res_val_q;
		end
	end

	always_comb begin
		stat.clear_done = clr_q == BIN_W'(NUM_BINS - 1);
		stat.is_read = action_q;
		stat.pt_valid = valid_q;
		stat.iter_done = cnt_q == 5'(SQRT_STEPS - 1);
		stat.rejected = rej_q;
		stat.out_busy = out_valid_q && out_stall;
	end

	assign out_valid = out_valid_q;
	assign status = out_st_q;
	assign bin_index = out_idx_q;
	assign range_value = out_val_q;

endmodule
`default_nettype wire

// ===== hdl/point_cloud_to_range_scan.sv =====
// Top level of the lidar point to range scan binning block.
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   action, x_coord, y_coord, point_valid, bin_select
// out       output     out_valid / out_stall status, bin_index, range_value
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// An add item that reaches a bin passes the 24 step square root unit, run alongside the
// 17 step CORDIC, then the window check, multiply, bin read and compare; a point rejected
// by the range or angle window ends after the multiply, an invalid point after decode, a
// read item after its bin read. One item is worked on at a time; the next one is accepted
// once the result sits in the output register. After reset a clearing pass empties all
// NUM_BINS bins (719 by default) while no item is accepted. A stalled output holds its item.
`timescale 1ns / 1ps
`default_nettype none
module point_cloud_to_range_scan
	import pc2rs_pkg::*;
#(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               action,
	input  wire logic signed [23:0] x_coord,
	input  wire logic signed [23:0] y_coord,
	input  wire logic               point_valid,
	input  wire logic [9:0]         bin_select,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic [9:0]              bin_index,
	output logic [23:0]             range_value,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [23:0]        cfg_data
);

	cmd_t cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	pc2rs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	pc2rs_dp #(
		.NUM_BINS (NUM_BINS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.action      (action),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.point_valid (point_valid),
		.bin_select  (bin_select),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.bin_index   (bin_index),
		.range_value (range_value)
	);

endmodule
`default_nettype wire

// ===== bench/point_cloud_to_range_scan_tb.sv =====
// Testbench for the range scan binning block: directed table, then random items checked by a predictor.
`timescale 1ns / 1ps
`default_nettype none
module point_cloud_to_range_scan_tb;
	import pc2rs_pkg::*;

	typedef struct {
		logic [2:0]  st;
		logic [9:0]  idx;
		logic [23:0] val;
	} scan_res_t;

	typedef struct {
		logic        act;
		int          x;
		int          y;
		logic        pv;
		int          sel;
		logic        typed;
		logic [2:0]  st;
		logic [9:0]  idx;
		logic [23:0] val;
	} stim_row_t;

	localparam int NBINS = NUM_BINS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic signed [23:0] x_coord = '0;
	logic signed [23:0] y_coord = '0;
	logic point_valid = 1'b0;
	logic [9:0] bin_select = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [9:0] bin_index;
	logic [23:0] range_value;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	point_cloud_to_range_scan dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [23:0] lo_range = 24'd7864;
	logic [23:0] hi_range = 24'd229376;
	int lo_angle = -205887;
	int hi_angle = 205887;
	logic [23:0] bin_rate = 24'd7489471;
	logic empty_reads_max = 1'b0;
	logic [23:0] bin_min_range [NBINS];

	scan_res_t pending_results[$];
	int failures = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	logic stopping = 1'b0;

	function automatic logic [23:0] planar_range(longint x, longint y);
		longint unsigned v, r, b;
		v = longint'(x * x) + longint'(y * y);
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r[23:0];
	endfunction

	function automatic int cordic_bearing(longint x, longint y);
		longint cx, cy, px;
		int z;
		z = 0;
		if (x == 0 && y == 0) return 0;
		cx = x * 256;
		cy = y * 256;
		if (x < 0) begin
			cx = -cx;
			cy = -cy;
			z = (y >= 0) ? PI_Q16 : -PI_Q16;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			px = cx;
			if (cy > 0) begin
				cx = cx + (cy >>> i);
				cy = cy - (px >>> i);
				z += int'(atan_q16(i[4:0]));
			end else begin
				cx = cx - (cy >>> i);
				cy = cy + (px >>> i);
				z -= int'(atan_q16(i[4:0]));
			end
		end
		return z;
	endfunction

	function automatic scan_res_t bin_point(stim_row_t s);
		scan_res_t res;
		logic [23:0] cur, r;
		int a;
		longint unsigned b;
		res.st = RES_BIN_READ;
		res.idx = '0;
		res.val = '0;
		if (s.act) begin
			cur = EMPTY_RANGE;
			if (s.sel < NBINS) begin
				cur = bin_min_range[s.sel];
				bin_min_range[s.sel] = EMPTY_RANGE;
			end
			if (cur == EMPTY_RANGE && empty_reads_max) cur = hi_range;
			res.idx = s.sel[9:0];
			res.val = cur;
		end else if (!s.pv) begin
			res.st = RES_INVALID;
		end else begin
			r = planar_range(s.x, s.y);
			res.val = r;
			if (r < lo_range) begin
				res.st = RES_BELOW_MIN;
			end else if (r > hi_range) begin
				res.st = RES_ABOVE_MAX;
			end else begin
				a = cordic_bearing(s.x, s.y);
				if (a < lo_angle || a > hi_angle) begin
					res.st = RES_ANGLE_OUT;
				end else begin
					b = (longint'(a - lo_angle) * longint'(bin_rate)) >> 32;
					if (b > NBINS - 1) b = NBINS - 1;
					res.idx = b[9:0];
					if (r < bin_min_range[b]) begin
						bin_min_range[b] = r;
						res.st = RES_STORED;
					end else begin
						res.st = RES_NOT_SMALLER;
					end
				end
			end
		end
		return res;
	endfunction

	task automatic send_item(stim_row_t s);
		scan_res_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= s.act;
		x_coord <= s.x[23:0];
		y_coord <= s.y[23:0];
		point_valid <= s.pv;
		bin_select <= s.sel[9:0];
		do @(posedge clk); while (in_stall);
		res = bin_point(s);
		if (s.typed) begin
			res.st = s.st;
			res.idx = s.idx;
			res.val = s.val;
		end
		pending_results.push_back(res);
	endtask

	task automatic write_reg(logic [2:0] index, logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
			CFG_RANGE_MIN: lo_range = data;
			CFG_RANGE_MAX: hi_range = data;
			CFG_ANGLE_MIN: lo_angle = int'(signed'(data[18:0]));
			CFG_ANGLE_MAX: hi_angle = int'(signed'(data[18:0]));
			CFG_BINS_PER_RAD: bin_rate = data;
			CFG_EMPTY_AS_MAX: empty_reads_max = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic int rand_coord();
		int w;
		int v;
		w = $urandom_range(24, 8);
		v = $urandom;
		v = v << (32 - w);
		return v >>> (32 - w);
	endfunction

	function automatic stim_row_t rand_item();
		stim_row_t s;
		int pick;
		s.typed = 1'b0;
		s.st = '0;
		s.idx = '0;
		s.val = '0;
		s.act = 1'b0;
		s.pv = 1'b1;
		s.sel = $urandom_range(NBINS - 1);
		s.x = rand_coord();
		s.y = rand_coord();
		pick = $urandom_range(99);
		if (pick < 25) begin
			s.act = 1'b1;
			if ($urandom_range(9) == 0) s.sel = $urandom_range(1023);
		end else if (pick < 32) begin
			s.pv = 1'b0;
		end else if (pick < 40) begin
			s.act = $urandom_range(1);
			s.pv = $urandom_range(1);
			s.sel = $urandom_range(1023);
			s.x = int'(signed'($urandom_range(24'hFFFFFF, 0)) << 8) >>> 8;
			s.y = int'(signed'($urandom_range(24'hFFFFFF, 0)) << 8) >>> 8;
		end else if (pick < 80) begin
			s.x = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(250000));
			s.y = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(250000));
		end
		return s;
	endfunction

	task automatic random_phase(int count);
		repeat (count) send_item(rand_item());
		drain();
	endtask

	stim_row_t directed_rows[] = '{
		'{1'b1, 0, 0, 1'b1, 0, 1'b1, RES_BIN_READ, 10'd0, 24'hFFFFFF},
		'{1'b1, 0, 0, 1'b1, 718, 1'b1, RES_BIN_READ, 10'd718, 24'hFFFFFF},
		'{1'b1, 0, 0, 1'b1, 1023, 1'b1, RES_BIN_READ, 10'd1023, 24'hFFFFFF},
		'{1'b0, 8388607, -8388608, 1'b0, 5, 1'b1, RES_INVALID, 10'd0, 24'd0},
		'{1'b0, 0, 0, 1'b1, 0, 1'b1, RES_BELOW_MIN, 10'd0, 24'd0},
		'{1'b0, -1, 0, 1'b1, 0, 1'b1, RES_BELOW_MIN, 10'd0, 24'd1},
		'{1'b0, -8388608, -8388608, 1'b1, 0, 1'b0, 0, 0, 0},
		'{1'b0, 8388607, 8388607, 1'b1, 0, 1'b0, 0, 0, 0},
		'{1'b0, 65536, 0, 1'b1, 0, 1'b0, 0, 0, 0},
		'{1'b0, 65536, 0, 1'b1, 0, 1'b0, 0, 0, 0},
		'{1'b0, 60000, 0, 1'b1, 0, 1'b0, 0, 0, 0},
		'{1'b0, -65536, 0, 1'b1, 0, 1'b0, 0, 0, 0},
		'{1'b0, -65536, -1, 1'b1, 0, 1'b0, 0, 0, 0},
		'{1'b0, 0, 65536, 1'b1, 0, 1'b0, 0, 0, 0},
		'{1'b0, 0, -65536, 1'b1, 0, 1'b0, 0, 0, 0},
		'{1'b0, 100000, -100000, 1'b1, 0, 1'b0, 0, 0, 0},
		'{1'b0, 7864, 0, 1'b1, 0, 1'b0, 0, 0, 0},
		'{1'b0, 0, 229376, 1'b1, 0, 1'b0, 0, 0, 0},
		'{1'b0, 0, 229377, 1'b1, 0, 1'b0, 0, 0, 0},
		'{1'b1, 0, 0, 1'b1, 359, 1'b0, 0, 0, 0},
		'{1'b1, 0, 0, 1'b1, 359, 1'b1, RES_BIN_READ, 10'd359, 24'hFFFFFF}
	};

	always @(posedge clk) begin
		scan_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				failures++;
				$display("%0t: unexpected result status %0d bin %0d range %0d",
					$time, status, bin_index, range_value);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st) begin
					failures++;
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
				end
				if (bin_index !== want.idx) begin
					failures++;
					$display("%0t: bin_index expected %0d actual %0d", $time, want.idx, bin_index);
				end
				if (range_value !== want.val) begin
					failures++;
					$display("%0t: range_value expected %0d actual %0d",
						$time, want.val, range_value);
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT && !stopping) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NBINS; i++) bin_min_range[i] = EMPTY_RANGE;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) send_item(directed_rows[i]);
		random_phase(300);

		write_reg(CFG_RANGE_MIN, 24'd0);
		write_reg(CFG_RANGE_MAX, 24'd16777214);
		write_reg(CFG_ANGLE_MIN, 24'(-205888));
		write_reg(CFG_ANGLE_MAX, 24'd205888);
		write_reg(CFG_BINS_PER_RAD, 24'd16777215);
		write_reg(CFG_EMPTY_AS_MAX, 24'd1);
		send_idle_pct = 70;
		random_phase(300);

		write_reg(CFG_RANGE_MIN, 24'd16777214);
		write_reg(CFG_ANGLE_MIN, 24'd0);
		write_reg(CFG_ANGLE_MAX, 24'd100000);
		write_reg(CFG_BINS_PER_RAD, 24'd1);
		write_reg(CFG_EMPTY_AS_MAX, 24'd0);
		send_idle_pct = 0;
		recv_stall_pct = 70;
		random_phase(40);
		write_reg(CFG_RANGE_MIN, 24'd1000);
		random_phase(260);

		write_reg(CFG_RANGE_MAX, 24'd300000);
		write_reg(CFG_ANGLE_MIN, 24'd100000);
		write_reg(CFG_ANGLE_MAX, 24'(-100000));
		write_reg(CFG_EMPTY_AS_MAX, 24'd1);
		send_idle_pct = 8;
		recv_stall_pct = 8;
		random_phase(100);

		write_reg(CFG_RANGE_MIN, 24'd7864);
		write_reg(CFG_RANGE_MAX, 24'd229376);
		write_reg(CFG_ANGLE_MIN, 24'(-205887));
		write_reg(CFG_ANGLE_MAX, 24'd205887);
		write_reg(CFG_BINS_PER_RAD, 24'($urandom_range(24'hFFFFFF, 1)));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_phase(500);

		stopping = 1'b1;
		if (failures == 0 && pending_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== point_cloud_to_range_scan.f =====
hdl/pc2rs_pkg.sv
hdl/pc2rs_ctrl.sv
hdl/pc2rs_dp.sv
hdl/point_cloud_to_range_scan.sv
bench/point_cloud_to_range_scan_tb.sv
